/* sv/i128alu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i128alu_pkg
// Types and constants shared by the signed wide ALU.
// ----------------------------------------------------------------------------
package i128alu_pkg;

  localparam int unsigned WordBitsDef = 128;
  localparam int unsigned HalfBits    = 64;
  localparam int unsigned OutBits     = 128;

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StOvf   = 2'd1,
    StDivZ  = 2'd2
  } status_e;

  typedef struct packed {
    logic        [1:0]  command;
    logic signed [63:0] a_high;
    logic        [63:0] a_low;
    logic signed [63:0] b_high;
    logic        [63:0] b_low;
  } req_t;

  typedef struct packed {
    logic signed [63:0] result_high;
    logic        [63:0] result_low;
    logic        [1:0]  status;
  } rsp_t;

  // start request from the sequencer to the iterative unit
  typedef struct packed {
    logic start;
    logic is_div;
  } unit_ctl_t;

endpackage

/* sv/i128alu_iter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i128alu_iter
// Shared shift/add unit: unsigned shift-add multiply or restoring divide on
// magnitudes, one bit per cycle.
// ----------------------------------------------------------------------------
module i128alu_iter #(
  parameter int unsigned WordBits = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  i128alu_pkg::unit_ctl_t    ctl_i,
  input  logic [WordBits-1:0]       x_i,
  input  logic [WordBits-1:0]       y_i,
  output logic                      done_o,
  output logic [2*WordBits-1:0]     prod_o,
  output logic [WordBits-1:0]       quot_o
);
  import i128alu_pkg::*;

  localparam int unsigned CntW = $clog2(WordBits + 1);

  logic                  busy_q, busy_d;
  logic                  div_q, div_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [WordBits-1:0]   acc_q, acc_d;   // product high / remainder
  logic [WordBits-1:0]   sh_q, sh_d;     // multiplier low / dividend->quotient
  logic [WordBits-1:0]   y_q, y_d;
  logic                  done_q, done_d;

  logic [WordBits:0]     sum;
  logic [WordBits:0]     rem_sh;
  logic [WordBits:0]     diff;

  always_comb begin
    sum    = {1'b0, acc_q} + {1'b0, (sh_q[0] ? y_q : '0)};
    rem_sh = {acc_q, sh_q[WordBits-1]};
    diff   = rem_sh - {1'b0, y_q};
    busy_d = busy_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    y_d    = y_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      div_d  = ctl_i.is_div;
      cnt_d  = CntW'(WordBits);
      acc_d  = '0;
      sh_d   = x_i;
      y_d    = y_i;
    end else if (busy_q) begin
      if (div_q) begin
        if (!diff[WordBits]) begin
          acc_d = diff[WordBits-1:0];
          sh_d  = {sh_q[WordBits-2:0], 1'b1};
        end else begin
          acc_d = rem_sh[WordBits-1:0];
          sh_d  = {sh_q[WordBits-2:0], 1'b0};
        end
      end else begin
        acc_d = sum[WordBits:1];
        sh_d  = {sum[0], sh_q[WordBits-1:1]};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      div_q  <= div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    y_q   <= y_d;
  end

  assign done_o = done_q;
  assign prod_o = {acc_q, sh_q};
  assign quot_o = sh_q;

endmodule

/* sv/int128_signed_alu_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int128_signed_alu_core
// Signed two's-complement ALU: add, subtract, multiply, divide with status.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals
// req     | in        | req_valid_i, req_stall_o, req_i
// rsp     | out       | rsp_valid_o, rsp_stall_i, rsp_o
//
// Add/subtract: result valid the cycle after the request is taken; with no
// stall the result goes out of SOut and the next request is taken in SIdle.
// Multiply/divide: after the request is taken, i128alu_iter runs WordBits
// steps of the shift/add loop, SRun sees done and moves to SFix, where the
// sign fix-up is registered, and SOut then presents the result. One request
// is in flight at a time; req_stall_o is high until the result has been
// taken, and rsp_stall_i holds the result in SOut. Reset clears all control
// state; no clearing pass.
// ----------------------------------------------------------------------------
module int128_signed_alu_core #(
  parameter int unsigned WordBits = i128alu_pkg::WordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_stall_o,
  input  i128alu_pkg::req_t    req_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_stall_i,
  output i128alu_pkg::rsp_t    rsp_o
);
  import i128alu_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SRun  = 2'd1;
  localparam logic [1:0] SFix  = 2'd2;
  localparam logic [1:0] SOut  = 2'd3;

  localparam int unsigned W = WordBits;

  logic [1:0]          state_q, state_d;
  logic [1:0]          cmd_q;
  logic [W-1:0]        b_q;
  logic                neg_q;
  rsp_t                rsp_q;
  unit_ctl_t           ctl;
  logic                done;
  logic [2*W-1:0]      prod;
  logic [W-1:0]        quot;

  logic [W-1:0]        a_w, b_w, a_mag, b_mag, bsel, r_as;
  logic                sa, sb, sr;
  logic [2*W-1:0]      pfin;
  logic [W-1:0]        qfin;
  logic                mul_ovf;
  logic [1:0]          st_as;

  logic                acc;
  assign acc = req_valid_i && !req_stall_o;
  assign req_stall_o = (state_q != SIdle);
  assign rsp_valid_o = (state_q == SOut);
  assign rsp_o = rsp_q;

  // narrow to the word, derive magnitudes, form the add/subtract result and its overflow status
  always_comb begin
    a_w   = W'({req_i.a_high, req_i.a_low});
    b_w   = W'({req_i.b_high, req_i.b_low});
    sa    = a_w[W-1];
    sb    = b_w[W-1];
    a_mag = sa ? (~a_w + 1'b1) : a_w;
    b_mag = sb ? (~b_w + 1'b1) : b_w;
    bsel  = (req_i.command == CmdSub) ? ~b_w : b_w;
    r_as  = a_w + bsel + W'(req_i.command == CmdSub);
    sr    = r_as[W-1];
    st_as = (sa == bsel[W-1] && sr != sa) ? StOvf : StOk;
  end

  assign ctl.start  = acc && (req_i.command == CmdMul || req_i.command == CmdDiv);
  assign ctl.is_div = (req_i.command == CmdDiv);

  i128alu_iter #(.WordBits(W)) u_iter (
    .clk_i, .rst_ni, .ctl_i(ctl), .x_i(a_mag), .y_i(b_mag),
    .done_o(done), .prod_o(prod), .quot_o(quot)
  );

  // sign fix-up of the unit's magnitude result (registered unit outputs)
  always_comb begin
    pfin    = neg_q ? (~prod + 1'b1) : prod;
    qfin    = neg_q ? (~quot + 1'b1) : quot;
    mul_ovf = (pfin[2*W-1:W] != {W{pfin[W-1]}});
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (acc) state_d = (ctl.start) ? SRun : SOut;
      SRun:  if (done) state_d = SFix;
      SFix:  state_d = SOut;
      SOut:  if (!rsp_stall_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q <= req_i.command;
      b_q   <= b_w;
      neg_q <= sa ^ sb;
      rsp_q <= {OutBits'($signed(r_as)), st_as};
    end
    if (state_q == SFix) begin
      if (cmd_q == CmdMul) begin
        rsp_q <= {OutBits'($signed(pfin[W-1:0])), (mul_ovf ? StOvf : StOk)};
      end else if (b_q == '0) begin
        rsp_q <= {{OutBits{1'b0}}, StDivZ};
      end else begin
        rsp_q <= {OutBits'($signed(qfin)),
                  ((!neg_q && qfin[W-1]) ? StOvf : StOk)};
      end
    end
  end

endmodule
